// ===== design/nppsc_pkg.sv =====
// Shared types and constants for the PBCH payload scramble/CRC core.
// No dependencies.
`timescale 1ns / 1ps
package nppsc_pkg;

    localparam logic [4:0] ILEAVE [32] = '{
        5'd16, 5'd23, 5'd18, 5'd17, 5'd8,  5'd30, 5'd10, 5'd6,
        5'd24, 5'd7,  5'd0,  5'd5,  5'd3,  5'd2,  5'd1,  5'd4,
        5'd9,  5'd11, 5'd12, 5'd13, 5'd14, 5'd15, 5'd19, 5'd20,
        5'd21, 5'd22, 5'd25, 5'd26, 5'd27, 5'd28, 5'd29, 5'd31
    };

    localparam logic [10:0] GOLD_NC  = 11'd1600;
    localparam logic [4:0]  M_L64    = 5'd26;
    localparam logic [4:0]  M_L8     = 5'd29;
    localparam logic [23:0] CRC_POLY = 24'hB2B117;

    typedef struct packed {
        logic [31:0] word;
        logic [31:0] prot;
        logic [10:0] skip;
    } t_job;

    typedef struct packed {
        logic [9:0] cell_id;
        logic       lmax_is_64;
    } t_cfg;

endpackage

// ===== design/nr_pbch_payload_scramble_crc_core.sv =====
// Top level of the PBCH payload scramble/CRC core: config registers, front
// end, job queue and back end. Depends on nppsc_pkg and its submodules.
//
//  channel   direction  handshake            payload
//  input     in         push / full          i_mib_bits .. i_kssb_msb
//  result    out        empty / pop          o_block_bits
//  config    in/out     APB psel/penable     cell_id @0x0, lmax_is_64 @0x4
//
// The back end takes one item at a time: a serial Gold sequence skip of
// 1600 + M*v positions, then the 32 bit scramble/CRC loop.
// Two further items may wait in the job queue; one result waits for pop.
// Reset is synchronous active low and clears queue, back end and config.
`timescale 1ns / 1ps
module nr_pbch_payload_scramble_crc_core import nppsc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [23:0] i_mib_bits,
    input  logic [3:0]  i_sfn_low,
    input  logic        i_half_frame,
    input  logic [5:0]  i_ssb_index,
    input  logic        i_kssb_msb,
    output logic        empty,
    input  logic        pop,
    output logic [55:0] o_block_bits,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    t_cfg r_cfg;
    t_job front_job, q_job;
    logic q_empty, q_rd;

    assign pready = 1'b1;
    assign prdata = paddr[2] ? {31'd0, r_cfg.lmax_is_64} : {22'd0, r_cfg.cell_id};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (psel && penable && pwrite) begin
            if (paddr[2]) r_cfg.lmax_is_64 <= pwdata[0];
            else          r_cfg.cell_id    <= pwdata[9:0];
        end
    end

    nppsc_front u_front (
        .i_mib_bits   (i_mib_bits),
        .i_sfn_low    (i_sfn_low),
        .i_half_frame (i_half_frame),
        .i_ssb_index  (i_ssb_index),
        .i_kssb_msb   (i_kssb_msb),
        .i_cfg        (r_cfg),
        .o_job        (front_job)
    );

    nppsc_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (push),
        .i_data  (front_job),
        .o_full  (full),
        .i_rd    (q_rd),
        .o_empty (q_empty),
        .o_data  (q_job)
    );

    nppsc_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_job_empty  (q_empty),
        .i_job        (q_job),
        .o_job_rd     (q_rd),
        .o_empty      (empty),
        .i_pop        (pop),
        .o_block_bits (o_block_bits)
    );
endmodule

// ===== design/nppsc_front.sv =====
// Front end: interleaves the message and timing bits, builds the protect
// mask and the Gold skip count. Depends on nppsc_pkg.
`timescale 1ns / 1ps
module nppsc_front import nppsc_pkg::*; (
    input  logic [23:0] i_mib_bits,
    input  logic [3:0]  i_sfn_low,
    input  logic        i_half_frame,
    input  logic [5:0]  i_ssb_index,
    input  logic        i_kssb_msb,
    input  t_cfg        i_cfg,
    output t_job        o_job
);
    logic [31:0] t;
    logic [31:0] a;
    logic [31:0] p;
    logic [4:0]  m;
    logic [1:0]  v;

    always_comb begin
        t = '0;
        t[14] = i_mib_bits[0];
        for (int i = 1; i < 7; i++) t[i-1] = i_mib_bits[i];
        for (int i = 7; i < 24; i++) t[i+8] = i_mib_bits[i];
        t[6]  = i_sfn_low[3];
        t[7]  = i_sfn_low[2];
        t[8]  = i_sfn_low[1];
        t[9]  = i_sfn_low[0];
        t[10] = i_half_frame;
        if (i_cfg.lmax_is_64) begin
            t[11] = i_ssb_index[5];
            t[12] = i_ssb_index[4];
            t[13] = i_ssb_index[3];
        end else begin
            t[11] = i_kssb_msb;
        end
        a = '0;
        for (int j = 0; j < 32; j++) a[ILEAVE[j]] = t[j];
        p = '0;
        p[ILEAVE[7]]  = 1'b1;
        p[ILEAVE[8]]  = 1'b1;
        p[ILEAVE[10]] = 1'b1;
        if (i_cfg.lmax_is_64) begin
            p[ILEAVE[11]] = 1'b1;
            p[ILEAVE[12]] = 1'b1;
            p[ILEAVE[13]] = 1'b1;
        end
        m = i_cfg.lmax_is_64 ? M_L64 : M_L8;
        v = i_sfn_low[2:1];
        o_job.word = a;
        o_job.prot = p;
        o_job.skip = GOLD_NC + 11'(m) * 11'(v);
    end
endmodule

// ===== design/nppsc_fifo.sv =====
// Two-entry job queue between front and back end. Depends on nppsc_pkg.
`timescale 1ns / 1ps
module nppsc_fifo import nppsc_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_wr,
    input  t_job i_data,
    output logic o_full,
    input  logic i_rd,
    output logic o_empty,
    output t_job o_data
);
    t_job       r_mem [2];
    logic       r_wptr, r_rptr;
    logic [1:0] r_cnt;
    logic       wr_en, rd_en;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign wr_en   = i_wr && !o_full;
    assign rd_en   = i_rd && !o_empty;
    assign o_data  = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (wr_en) r_mem[r_wptr] <= i_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= 1'b0;
            r_rptr <= 1'b0;
            r_cnt  <= 2'd0;
        end else begin
            if (wr_en) r_wptr <= ~r_wptr;
            if (rd_en) r_rptr <= ~r_rptr;
            r_cnt <= r_cnt + 2'(wr_en) - 2'(rd_en);
        end
    end
endmodule

// ===== design/nppsc_back.sv =====
// Back end: serial Gold sequence skip, scrambling and CRC24C, then the
// result register. Depends on nppsc_pkg.
`timescale 1ns / 1ps
module nppsc_back import nppsc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cfg        i_cfg,
    input  logic        i_job_empty,
    input  t_job        i_job,
    output logic        o_job_rd,
    output logic        o_empty,
    input  logic        i_pop,
    output logic [55:0] o_block_bits
);
    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_SKIP = 4'b0010,
        S_RUN  = 4'b0100,
        S_DONE = 4'b1000
    } t_state;

    t_state      r_state, n_state;
    logic [30:0] r_gx1, r_gx2;
    logic [10:0] r_cnt;
    logic [4:0]  r_idx;
    logic [31:0] r_word, r_prot, r_res;
    logic [23:0] r_crc;
    logic        r_ovalid;
    logic [55:0] r_out;
    logic [30:0] gx1_sh, gx2_sh;
    logic        bit_s, fb;
    logic [23:0] crc_nx, crc_rev;
    logic        out_free;

    assign gx1_sh   = {r_gx1[3] ^ r_gx1[0], r_gx1[30:1]};
    assign gx2_sh   = {r_gx2[3] ^ r_gx2[2] ^ r_gx2[1] ^ r_gx2[0], r_gx2[30:1]};
    assign bit_s    = r_word[r_idx] ^ (!r_prot[r_idx] && (r_gx1[0] ^ r_gx2[0]));
    assign fb       = r_crc[23] ^ bit_s;
    assign crc_nx   = {r_crc[22:0], 1'b0} ^ (fb ? CRC_POLY : 24'd0);
    assign out_free = !r_ovalid || i_pop;
    assign o_job_rd = (r_state == S_IDLE) && !i_job_empty;
    assign o_empty  = !r_ovalid;
    assign o_block_bits = r_out;

    always_comb begin
        for (int i = 0; i < 24; i++) crc_rev[i] = r_crc[23-i];
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (!i_job_empty) n_state = S_SKIP;
            S_SKIP: if (r_cnt == 11'd1) n_state = S_RUN;
            S_RUN:  if (r_idx == 5'd31) n_state = S_DONE;
            S_DONE: if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_DONE && out_free) r_ovalid <= 1'b1;
            else if (i_pop) r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                r_gx1  <= 31'd1;
                r_gx2  <= {21'd0, i_cfg.cell_id};
                r_cnt  <= i_job.skip;
                r_word <= i_job.word;
                r_prot <= i_job.prot;
                r_idx  <= 5'd0;
                r_crc  <= 24'd0;
            end
            S_SKIP: begin
                r_gx1 <= gx1_sh;
                r_gx2 <= gx2_sh;
                r_cnt <= r_cnt - 11'd1;
            end
            S_RUN: begin
                // advance the sequence only on scrambled positions
                if (!r_prot[r_idx]) begin
                    r_gx1 <= gx1_sh;
                    r_gx2 <= gx2_sh;
                end
                r_res[r_idx] <= bit_s;
                r_crc <= crc_nx;
                r_idx <= r_idx + 5'd1;
            end
            S_DONE: begin
                if (out_free) r_out <= {crc_rev, r_res};
            end
            default: ;
        endcase
    end
endmodule

// ===== design/nppsc_checker.sv =====
// Port-level checks for the PBCH payload scramble/CRC core, with bind.
// Depends only on the top level's ports.
`timescale 1ns / 1ps
module nppsc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        push,
    input logic        full,
    input logic        empty,
    input logic        pop,
    input logic [55:0] o_block_bits,
    input logic        pready
);
    a_rst_empty: assert property (@(posedge i_clk) !i_rst_n |=> empty && !full)
        else $error("queues not cleared by reset");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_block_bits)))
        else $error("waiting result changed or dropped");
    // the job queue only fills on an accepted transaction
    a_full_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(full) |-> $past(push))
        else $error("queue filled without a push");
    a_ready: assert property (@(posedge i_clk) pready)
        else $error("pready low");
endmodule

bind nr_pbch_payload_scramble_crc_core nppsc_checker u_nppsc_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .push         (push),
    .full         (full),
    .empty        (empty),
    .pop          (pop),
    .o_block_bits (o_block_bits),
    .pready       (pready)
);
